// ===== hdl/hglb_pkg.sv =====
// hglb_pkg: types, register codes and constants of the hysteresis gated load blend
// used by hglb_front, hglb_queue, hglb_back and the top level
`timescale 1ns / 1ps

package hglb_pkg;

  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 23;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [22:0] HIGH_OFFSET_RST = 23'd10000;
  localparam logic [22:0] BAND_WIDTH_RST  = 23'd100;
  localparam logic [16:0] DECAY_STEP_RST  = 17'd3277;
  localparam logic [16:0] RECOV_STEP_RST  = 17'd65536;
  localparam logic [51:0] ROUND_HALF      = 52'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_OFFSET   = 3'd0,
    REG_BAND_WIDTH    = 3'd1,
    REG_DECAY_STEP    = 3'd2,
    REG_RECOVERY_STEP = 3'd3
  } cfg_reg_t;

  // one classified beat between front and back
  typedef struct packed {
    logic               flag;
    logic        [16:0] blend;
    logic signed [33:0] base_sum;
    logic signed [31:0] target;
    logic signed [31:0] addend;
    logic signed [31:0] subtrahend;
  } entry_t;

endpackage

// ===== hdl/hglb_front.sv =====
// hglb_front: config registers, hysteresis flag and blend factor update per input beat
// depends on hglb_pkg
`timescale 1ns / 1ps

module hglb_front import hglb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [23:0]    raw_value,
  input  logic signed [23:0]    threshold_base,
  input  logic                  gate,
  input  logic signed [31:0]    term_one,
  input  logic signed [31:0]    term_two,
  input  logic signed [31:0]    term_three,
  input  logic signed [31:0]    blend_target,
  input  logic signed [31:0]    load_addend,
  input  logic signed [31:0]    load_subtrahend,
  output logic                  push_valid,
  input  logic                  push_ready,
  output entry_t                push_entry
);

  logic [22:0] high_offset;
  logic [22:0] band_width;
  logic [16:0] decay_step;
  logic [16:0] recovery_step;
  logic        over_flag;
  logic [16:0] blend_factor;

  logic signed [25:0] raw_ext;
  logic signed [25:0] upper;
  logic signed [25:0] lower;
  logic               over_flag_next;
  logic signed [17:0] blend_dec;
  logic        [17:0] blend_inc;
  logic        [16:0] blend_factor_next;
  logic               accept;

  assign cfg_ready  = 1'b1;
  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_offset   <= HIGH_OFFSET_RST;
      band_width    <= BAND_WIDTH_RST;
      decay_step    <= DECAY_STEP_RST;
      recovery_step <= RECOV_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HIGH_OFFSET:   high_offset   <= cfg_data;
        REG_BAND_WIDTH:    band_width    <= cfg_data;
        REG_DECAY_STEP:    decay_step    <= cfg_data[16:0];
        REG_RECOVERY_STEP: recovery_step <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    raw_ext = {{2{raw_value[23]}}, raw_value};
    upper   = $signed({{2{threshold_base[23]}}, threshold_base}) +
              $signed({3'b000, high_offset});
    lower   = upper - $signed({3'b000, band_width});
    priority if (raw_ext >= upper) begin
      over_flag_next = 1'b1;
    end else if (raw_ext < lower) begin
      over_flag_next = 1'b0;
    end else begin
      over_flag_next = over_flag;
    end

    blend_dec = $signed({1'b0, blend_factor}) - $signed({1'b0, decay_step});
    blend_inc = {1'b0, blend_factor} + {1'b0, recovery_step};
    if (gate && !over_flag_next) begin
      blend_factor_next = blend_dec[17] ? 17'd0 : blend_dec[16:0];
    end else begin
      blend_factor_next = (blend_inc > {1'b0, ONE_Q16}) ? ONE_Q16 : blend_inc[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      over_flag    <= 1'b0;
      blend_factor <= ONE_Q16;
    end else if (accept) begin
      over_flag    <= over_flag_next;
      blend_factor <= blend_factor_next;
    end
  end

  always_comb begin
    push_entry.flag       = over_flag_next;
    push_entry.blend      = blend_factor_next;
    push_entry.base_sum   = $signed({{2{term_one[31]}}, term_one}) +
                            $signed({{2{term_two[31]}}, term_two}) +
                            $signed({{2{term_three[31]}}, term_three});
    push_entry.target     = blend_target;
    push_entry.addend     = load_addend;
    push_entry.subtrahend = load_subtrahend;
  end

endmodule

// ===== hdl/hglb_queue.sv =====
// hglb_queue: short register queue between front and back
// depends on hglb_pkg
`timescale 1ns / 1ps

module hglb_queue import hglb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== hdl/hglb_back.sv =====
// hglb_back: two stage blend datapath, products then round, sum and saturate
// depends on hglb_pkg
`timescale 1ns / 1ps

module hglb_back import hglb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  entry_t             pop_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] load_out,
  output logic               flag_out,
  output logic [16:0]        blend_out
);

  logic               prod_valid;
  logic signed [51:0] prod_base;
  logic signed [49:0] prod_target;
  logic signed [31:0] prod_addend;
  logic signed [31:0] prod_subtrahend;
  logic               prod_flag;
  logic [16:0]        prod_blend;

  logic               out_adv;
  logic               prod_adv;
  logic [16:0]        weight;
  logic signed [51:0] acc;
  logic signed [35:0] rounded;
  logic signed [37:0] total;
  logic signed [31:0] load_sat;

  assign out_adv   = !out_valid || out_ready;
  assign prod_adv  = !prod_valid || out_adv;
  assign pop_ready = prod_adv;
  assign weight    = ONE_Q16 - pop_entry.blend;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_adv) begin
      prod_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv && pop_valid) begin
      prod_base       <= $signed({1'b0, weight}) * pop_entry.base_sum;
      prod_target     <= $signed({1'b0, pop_entry.blend}) * pop_entry.target;
      prod_addend     <= pop_entry.addend;
      prod_subtrahend <= pop_entry.subtrahend;
      prod_flag       <= pop_entry.flag;
      prod_blend      <= pop_entry.blend;
    end
  end

  always_comb begin
    acc     = prod_base + {{2{prod_target[49]}}, prod_target} + $signed(ROUND_HALF);
    rounded = acc[51:16];
    total   = {{2{rounded[35]}}, rounded} +
              {{6{prod_addend[31]}}, prod_addend} -
              {{6{prod_subtrahend[31]}}, prod_subtrahend};
    priority if (total > 38'sd2147483647) begin
      load_sat = 32'sh7FFF_FFFF;
    end else if (total < -38'sd2147483648) begin
      load_sat = 32'sh8000_0000;
    end else begin
      load_sat = total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && prod_valid) begin
      load_out  <= load_sat;
      flag_out  <= prod_flag;
      blend_out <= prod_blend;
    end
  end

endmodule

// ===== hdl/hysteresis_gated_load_blend.sv =====
// hysteresis_gated_load_blend: top level, front classifier, beat queue and blend datapath
// depends on hglb_pkg, hglb_front, hglb_queue, hglb_back
//
// channel  direction  handshake              payload
// cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
// in       in         in_valid / in_ready    raw_value .. load_subtrahend
// out      out        out_valid / out_ready  load_out, flag_out, blend_out
//
// one beat per cycle in and out while out_ready is high
// the queue is written at the accepting edge, then the product and output registers
// reset clears the flag, sets the blend factor to one, loads register defaults
// and empties the queue; cfg_ready is always high
// a stalled output fills the pipeline, then the queue, then drops in_ready
`timescale 1ns / 1ps

module hysteresis_gated_load_blend import hglb_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [23:0]    raw_value,
  input  logic signed [23:0]    threshold_base,
  input  logic                  gate,
  input  logic signed [31:0]    term_one,
  input  logic signed [31:0]    term_two,
  input  logic signed [31:0]    term_three,
  input  logic signed [31:0]    blend_target,
  input  logic signed [31:0]    load_addend,
  input  logic signed [31:0]    load_subtrahend,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    load_out,
  output logic                  flag_out,
  output logic [16:0]           blend_out
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  hglb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_value       (raw_value),
    .threshold_base  (threshold_base),
    .gate            (gate),
    .term_one        (term_one),
    .term_two        (term_two),
    .term_three      (term_three),
    .blend_target    (blend_target),
    .load_addend     (load_addend),
    .load_subtrahend (load_subtrahend),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_entry      (push_entry)
  );

  hglb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  hglb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .load_out  (load_out),
    .flag_out  (flag_out),
    .blend_out (blend_out)
  );

endmodule
